// File: design/assert_macros.svh
// Assertion macros for the signature parser modules; dsig_emit is the one that uses them.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define DSIG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define DSIG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/dsig_pkg.sv
// Types and constants for the DER signature parser.
// Depends on nothing; used by every module of the block.
package dsig_pkg;

	// Default sizes of the block.
	localparam int INT_BYTES_DEF     = 32;
	localparam int MAX_DER_BYTES_DEF = 72;
	localparam int MIN_DER_BYTES     = 70;

	// DER tag values.
	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] TAG_INTEGER  = 8'h02;
	localparam logic [7:0] PAD_ZERO     = 8'h00;
	localparam logic [7:0] PAD_ONES     = 8'hff;

	typedef logic [63:0] word_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOTAL_LEN = 3'd1,
		ST_SEQ_TAG   = 3'd2,
		ST_SEQ_LEN   = 3'd3,
		ST_INT_TAG   = 3'd4,
		ST_INT_LEN   = 3'd5,
		ST_PADDING   = 3'd6,
		ST_TRAILING  = 3'd7
	} status_t;

	// Parser phases; the S integer reuses the R phases shifted by five.
	typedef enum logic [3:0] {
		PH_SEQ_TAG   = 4'd0,
		PH_SEQ_LEN   = 4'd1,
		PH_INT_TAG   = 4'd2,
		PH_INT_LEN   = 4'd3,
		PH_FIRST     = 4'd4,
		PH_SECOND    = 4'd5,
		PH_REST      = 4'd6,
		PH_S_INT_TAG = 4'd7,
		PH_S_INT_LEN = 4'd8,
		PH_S_FIRST   = 4'd9,
		PH_S_SECOND  = 4'd10,
		PH_S_REST    = 4'd11,
		PH_DONE      = 4'd12,
		PH_FAIL      = 4'd13
	} phase_t;

	// Hand-off from the parser to the word emitter.
	typedef struct packed {
		logic    load;
		status_t status;
	} load_t;

endpackage

// File: design/dsig_byte_if.sv
// Byte channel carrying the DER signature into the parser.
// Depends on nothing.
interface dsig_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] der_byte;
	logic       final_byte;

	modport source(output valid, der_byte, final_byte, input ready);
	modport sink(input valid, der_byte, final_byte, output ready);
endinterface

// File: design/dsig_word_if.sv
// Word channel carrying decoded R and S words or an error item.
// Depends on nothing.
interface dsig_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] sig_word;
	logic [2:0]  word_index;
	logic [2:0]  status;
	logic        run_end;

	modport source(output valid, sig_word, word_index, status, run_end, input ready);
	modport sink(input valid, sig_word, word_index, status, run_end, output ready);
endinterface

// File: design/der_ecdsa_signature_parser_top.sv
// Top level of the DER ECDSA signature parser.
// Depends on dsig_pkg, dsig_byte_if, dsig_word_if, dsig_parse and dsig_emit.

// The block takes a DER encoded ECDSA signature one byte per beat on der, the
// last byte marked by final_byte, and sends on result either 2*ceil(INT_BYTES/8)
// big-endian words (R words first, high word first, then S) with status zero,
// or a single error item with a zero word and the failing status; run_end marks
// the last beat of each signature. Bytes are accepted at one per cycle except
// while a final byte waits: each byte is taken into the input register and is
// checked and stored by the parser from there. The result words follow one per
// cycle from the emitter buffer when result is ready, starting the cycle after
// the final byte is processed, while bytes of the next signature keep streaming
// in. The final byte of a signature waits in the input register only while the
// emitter still holds words of the previous one, so a signature shorter than
// the word count of its predecessor stalls; at the default size a valid
// signature of 70 to 72 bytes stalls only while result is not ready.
module der_ecdsa_signature_parser_top #(
	parameter int INT_BYTES     = dsig_pkg::INT_BYTES_DEF,
	parameter int MAX_DER_BYTES = dsig_pkg::MAX_DER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dsig_byte_if.sink   der,
	dsig_word_if.source result
);
	import dsig_pkg::*;

	localparam int NWORDS = 2 * ((INT_BYTES + 7) / 8);

	load_t load;
	word_t words [NWORDS];
	logic  can_load;

	dsig_parse #(
		.INT_BYTES     (INT_BYTES),
		.MAX_DER_BYTES (MAX_DER_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.der      (der),
		.can_load (can_load),
		.load     (load),
		.words    (words)
	);

	dsig_emit #(
		.INT_BYTES (INT_BYTES)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.words    (words),
		.can_load (can_load),
		.result   (result)
	);

endmodule

// File: design/dsig_parse.sv
// Byte parser: input register, DER structure checks and R/S byte store.
// Depends on dsig_pkg and dsig_byte_if; feeds dsig_emit.
module dsig_parse #(
	parameter int INT_BYTES     = dsig_pkg::INT_BYTES_DEF,
	parameter int MAX_DER_BYTES = dsig_pkg::MAX_DER_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dsig_byte_if.sink             der,
	input  logic                  can_load,
	output dsig_pkg::load_t       load,
	output dsig_pkg::word_t       words [2*((INT_BYTES+7)/8)]
);
	import dsig_pkg::*;

	localparam int WPI   = (INT_BYTES + 7) / 8;
	localparam int IDX_W = $clog2(INT_BYTES);
	localparam logic [7:0] IB8     = 8'(INT_BYTES);
	localparam logic [6:0] MIN_BC  = 7'(MIN_DER_BYTES);
	localparam logic [6:0] MAX_BC  = 7'(MAX_DER_BYTES);
	localparam logic [6:0] BC_SAT  = 7'd127;

	// Input register.
	logic       valid_s1;
	logic [7:0] der_s1;
	logic       final_s1;
	logic       adv;

	// Parser state.
	phase_t     phase_q, phase_d;
	status_t    err_q, err_d;
	logic [6:0] bc_q, bc_inc;
	logic [7:0] elem_q, elem_d;
	logic [6:0] seq_len_q, seq_len_d;
	logic [7:0] first_q, first_d;
	logic [1:0] ovf_q, ovf_d;
	logic [7:0] r_q [INT_BYTES];
	logic [7:0] s_q [INT_BYTES];
	logic [7:0] r_d [INT_BYTES];
	logic [7:0] s_d [INT_BYTES];

	// Decode helpers.
	logic              which;
	logic [7:0]        b;
	logic [7:0]        rem_dec;
	logic              body_end;
	logic signed [9:0] room;
	logic              len_bad;
	logic              pad_bad;
	logic              body;
	logic              wr;
	logic [7:0]        pos_full;
	logic [IDX_W-1:0]  idx;
	phase_t            after_ph;
	status_t           fin_status;
	word_t             words_r [WPI];
	word_t             words_s [WPI];

	// A beat moves on when it is not the last one or the emitter can take a result.
	assign adv       = valid_s1 && (!final_s1 || can_load);
	assign der.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (der.valid && der.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (der.valid && der.ready) begin
			der_s1   <= der.der_byte;
			final_s1 <= der.final_byte;
		end
	end

	// Shared conditions for the current byte.
	assign b        = der_s1;
	assign which    = (phase_q >= PH_S_INT_TAG) && (phase_q <= PH_S_REST);
	assign rem_dec  = elem_q - 8'd1;
	assign body_end = (rem_dec == 8'd0);
	assign room     = $signed({3'b000, seq_len_q}) - $signed({3'b000, bc_q}) + 10'sd1;
	assign len_bad  = b[7] || (b == 8'd0) || ($signed({2'b00, b}) > room);
	assign pad_bad  = ((first_q == PAD_ZERO) && !b[7]) || ((first_q == PAD_ONES) && b[7]);
	assign after_ph = which ? PH_DONE : PH_S_INT_TAG;
	assign bc_inc   = (bc_q == BC_SAT) ? BC_SAT : bc_q + 7'd1;

	// Next phase and first error.
	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		unique case (phase_q) inside
			PH_SEQ_TAG: begin
				if (b != TAG_SEQUENCE) begin
					phase_d = PH_FAIL;
					err_d   = ST_SEQ_TAG;
				end else begin
					phase_d = PH_SEQ_LEN;
				end
			end
			PH_SEQ_LEN: begin
				if (b[7] || (b == 8'd0)) begin
					phase_d = PH_FAIL;
					err_d   = ST_SEQ_LEN;
				end else begin
					phase_d = PH_INT_TAG;
				end
			end
			PH_INT_TAG, PH_S_INT_TAG: begin
				if (b != TAG_INTEGER) begin
					phase_d = PH_FAIL;
					err_d   = ST_INT_TAG;
				end else begin
					phase_d = which ? PH_S_INT_LEN : PH_INT_LEN;
				end
			end
			PH_INT_LEN, PH_S_INT_LEN: begin
				if (len_bad) begin
					phase_d = PH_FAIL;
					err_d   = ST_INT_LEN;
				end else begin
					phase_d = which ? PH_S_FIRST : PH_FIRST;
				end
			end
			PH_FIRST, PH_S_FIRST: begin
				phase_d = body_end ? after_ph : (which ? PH_S_SECOND : PH_SECOND);
			end
			PH_SECOND, PH_S_SECOND: begin
				if (pad_bad) begin
					phase_d = PH_FAIL;
					err_d   = ST_PADDING;
				end else begin
					phase_d = body_end ? after_ph : (which ? PH_S_REST : PH_REST);
				end
			end
			PH_REST, PH_S_REST: begin
				if (body_end) begin
					phase_d = after_ph;
				end
			end
			PH_DONE: begin
				phase_d = PH_FAIL;
				err_d   = ST_TRAILING;
			end
			default: begin
			end
		endcase
	end

	// Length, first byte and overflow bookkeeping.
	always_comb begin
		seq_len_d = seq_len_q;
		elem_d    = elem_q;
		first_d   = first_q;
		ovf_d     = ovf_q;
		body      = 1'b0;
		case (phase_q) inside
			PH_SEQ_LEN: seq_len_d = b[6:0];
			PH_INT_LEN, PH_S_INT_LEN: begin
				if (!len_bad) begin
					elem_d = b;
				end
			end
			PH_FIRST, PH_S_FIRST: begin
				first_d = b;
				body    = 1'b1;
				if (b[7]) begin
					ovf_d[which] = 1'b1;
				end
			end
			PH_SECOND, PH_S_SECOND: body = !pad_bad;
			PH_REST, PH_S_REST: body = 1'b1;
			default: begin
			end
		endcase
		if (body) begin
			elem_d = rem_dec;
			if ((b != 8'd0) && (elem_q > IB8)) begin
				ovf_d[which] = 1'b1;
			end
		end
	end

	// Content bytes land right-aligned; bytes beyond the store are dropped.
	assign wr       = body && (elem_q >= 8'd1) && (elem_q <= IB8);
	assign pos_full = IB8 - elem_q;
	assign idx      = pos_full[IDX_W-1:0];

	always_comb begin
		r_d = r_q;
		s_d = s_q;
		for (int i = 0; i < INT_BYTES; i++) begin
			if (wr && (idx == IDX_W'(i))) begin
				if (which) begin
					s_d[i] = b;
				end else begin
					r_d[i] = b;
				end
			end
		end
	end

	// Status of a signature that ends with this byte.
	always_comb begin
		if ((bc_inc < MIN_BC) || (bc_inc > MAX_BC)) begin
			fin_status = ST_TOTAL_LEN;
		end else if ((err_d == ST_SEQ_TAG) || (err_d == ST_SEQ_LEN)) begin
			fin_status = err_d;
		end else if (({1'b0, seq_len_d} + 8'd2) != {1'b0, bc_inc}) begin
			fin_status = ST_SEQ_LEN;
		end else if (err_d != ST_OK) begin
			fin_status = err_d;
		end else if (phase_d == PH_DONE) begin
			fin_status = ST_OK;
		end else if (phase_d == PH_SEQ_TAG) begin
			fin_status = ST_SEQ_TAG;
		end else if (phase_d == PH_SEQ_LEN) begin
			fin_status = ST_SEQ_LEN;
		end else if ((phase_d == PH_INT_TAG) || (phase_d == PH_S_INT_TAG)) begin
			fin_status = ST_INT_TAG;
		end else begin
			fin_status = ST_INT_LEN;
		end
	end

	// Pack the updated stores into big-endian words; zero past the integer or on overflow.
	for (genvar w = 0; w < WPI; w++) begin : g_word
		for (genvar k = 0; k < 8; k++) begin : g_byte
			if (w * 8 + k < INT_BYTES) begin : g_in
				assign words_r[w][63-8*k -: 8] = r_d[w*8+k];
				assign words_s[w][63-8*k -: 8] = s_d[w*8+k];
			end else begin : g_pad
				assign words_r[w][63-8*k -: 8] = 8'h00;
				assign words_s[w][63-8*k -: 8] = 8'h00;
			end
		end
		assign words[w]       = ovf_d[0] ? '0 : words_r[w];
		assign words[WPI + w] = ovf_d[1] ? '0 : words_s[w];
	end

	assign load.load   = adv && final_s1;
	assign load.status = fin_status;

	// State update; the final byte returns everything to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEQ_TAG;
			err_q     <= ST_OK;
			bc_q      <= '0;
			elem_q    <= '0;
			seq_len_q <= '0;
			first_q   <= '0;
			ovf_q     <= '0;
			for (int i = 0; i < INT_BYTES; i++) begin
				r_q[i] <= '0;
				s_q[i] <= '0;
			end
		end else if (adv) begin
			if (final_s1) begin
				phase_q   <= PH_SEQ_TAG;
				err_q     <= ST_OK;
				bc_q      <= '0;
				elem_q    <= '0;
				seq_len_q <= '0;
				first_q   <= '0;
				ovf_q     <= '0;
				for (int i = 0; i < INT_BYTES; i++) begin
					r_q[i] <= '0;
					s_q[i] <= '0;
				end
			end else begin
				phase_q   <= phase_d;
				err_q     <= err_d;
				bc_q      <= bc_inc;
				elem_q    <= elem_d;
				seq_len_q <= seq_len_d;
				first_q   <= first_d;
				ovf_q     <= ovf_d;
				r_q       <= r_d;
				s_q       <= s_d;
			end
		end
	end

endmodule

// File: design/dsig_emit.sv
// Result emitter: holds one decoded signature and sends it word by word.
// Depends on dsig_pkg, dsig_word_if and assert_macros.svh.
`include "assert_macros.svh"

module dsig_emit #(
	parameter int INT_BYTES = dsig_pkg::INT_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dsig_pkg::load_t  load,
	input  dsig_pkg::word_t  words [2*((INT_BYTES+7)/8)],
	output logic             can_load,
	dsig_word_if.source      result
);
	import dsig_pkg::*;

	localparam int NWORDS = 2 * ((INT_BYTES + 7) / 8);
	localparam int CNT_W  = $clog2(NWORDS);
	localparam logic [CNT_W-1:0] LAST_W = CNT_W'(NWORDS - 1);

	logic             busy_q;
	logic             err_q;
	logic [CNT_W-1:0] w_q;
	status_t          status_q;
	word_t            words_q [NWORDS];
	logic             fire;
	logic             last;

	assign fire     = result.valid && result.ready;
	assign last     = err_q || (w_q == LAST_W);
	assign can_load = !busy_q || (fire && last);

	// Output beat; an error item carries a zero word at index zero.
	assign result.valid      = busy_q;
	assign result.sig_word   = err_q ? '0 : words_q[0];
	assign result.word_index = err_q ? 3'd0 : 3'(w_q);
	assign result.status     = status_q;
	assign result.run_end    = last;

	// Sequencing of the result beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			err_q  <= 1'b0;
			w_q    <= '0;
		end else if (load.load) begin
			busy_q <= 1'b1;
			err_q  <= (load.status != ST_OK);
			w_q    <= '0;
		end else if (fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				w_q <= w_q + 1'b1;
			end
		end
	end

	// Word buffer shifts toward the head as beats leave.
	always_ff @(posedge clk) begin
		if (load.load) begin
			words_q  <= words;
			status_q <= load.status;
		end else if (fire && !last) begin
			for (int i = 0; i < NWORDS - 1; i++) begin
				words_q[i] <= words_q[i+1];
			end
		end
	end

	`DSIG_ASSERT(a_load_when_free, clk, arst_n, load.load |-> can_load, "result loaded while busy")
	`DSIG_ASSERT(a_error_single, clk, arst_n, (busy_q && err_q) |-> result.run_end, "error item not last")
	`DSIG_ASSERT_NEXT(a_index_steps, clk, arst_n, fire && !last && !load.load, w_q == $past(w_q) + 1'b1, "word index skipped")
	`DSIG_ASSERT_NEXT(a_idle_after_end, clk, arst_n, fire && last && !load.load, !busy_q, "beat after run end")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for der_ecdsa_signature_parser_top: streams DER signatures byte by byte
// and checks every R/S word or error beat against an in-bench parser.
// Depends on dsig_pkg, dsig_byte_if, dsig_word_if and the parser top level.
module testbench;
	import dsig_pkg::*;

	localparam int SIG_INT_BYTES = INT_BYTES_DEF;
	localparam int SIG_MAX_BYTES = MAX_DER_BYTES_DEF;
	localparam int WORDS_PER_INT = (SIG_INT_BYTES + 7) / 8;
	localparam logic [3:0] S_SHIFT = PH_S_INT_TAG - PH_INT_TAG;
	localparam logic [6:0] COUNT_CEIL = 7'd127;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_BYTES = 60;

	// Shapes of integer content the generator can produce.
	typedef enum {INT_POS, INT_PADDED, INT_NEG, INT_RAW} int_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} der_beat_t;

	typedef struct packed {
		word_t      word;
		logic [2:0] index;
		status_t    status;
		logic       run_end;
	} rs_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dsig_byte_if der_if();
	dsig_word_if res_if();

	der_ecdsa_signature_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.der(der_if),
		.result(res_if)
	);

	always #5 clk = ~clk;

	der_beat_t  der_pending[$];
	der_beat_t  next_beat;
	rs_word_t   words_due[$];
	rs_word_t   word_head;
	logic [7:0] sig_buf[$];
	int bytes_queued = 0;
	int bytes_taken = 0;
	int mismatches = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	logic byte_took = 1'b0;
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;

	// Parser state mirrored in the bench.
	phase_t     prs_phase;
	logic [6:0] prs_count;
	logic [7:0] prs_left;
	logic [6:0] prs_seq_len;
	logic [7:0] prs_lead;
	status_t    prs_err;
	logic [1:0] int_dropped;
	logic [7:0] r_val[SIG_INT_BYTES];
	logic [7:0] s_val[SIG_INT_BYTES];

	function automatic void parse_clear();
		prs_phase = PH_SEQ_TAG;
		prs_count = '0;
		prs_left = '0;
		prs_seq_len = '0;
		prs_lead = '0;
		prs_err = ST_OK;
		int_dropped = '0;
		for (int i = 0; i < SIG_INT_BYTES; i++) begin
			r_val[i] = '0;
			s_val[i] = '0;
		end
	endfunction

	function automatic phase_t on_side(phase_t p, logic s_side);
		return s_side ? phase_t'(p + S_SHIFT) : p;
	endfunction

	function automatic void parse_fail(status_t code);
		prs_err = code;
		prs_phase = PH_FAIL;
	endfunction

	// Stores one content byte right-aligned and closes the integer on its last byte.
	function automatic void content_byte(logic s_side, logic [7:0] b);
		int left;
		left = int'(prs_left);
		if (b != PAD_ZERO && left > SIG_INT_BYTES)
			int_dropped[s_side] = 1'b1;
		if (left >= 1 && left <= SIG_INT_BYTES) begin
			if (s_side)
				s_val[SIG_INT_BYTES - left] = b;
			else
				r_val[SIG_INT_BYTES - left] = b;
		end
		prs_left = prs_left - 8'd1;
		if (prs_left == 8'd0)
			prs_phase = s_side ? PH_DONE : PH_S_INT_TAG;
	endfunction

	// Consumes one accepted byte and queues the words or the error beat it ends with.
	function automatic void parse_beat(logic [7:0] b, logic is_last);
		phase_t   ph;
		logic     s_side;
		int       room;
		int       base;
		status_t  st;
		rs_word_t w;
		word_t    v;
		ph = prs_phase;
		s_side = 1'b0;
		if (ph >= PH_S_INT_TAG && ph <= PH_S_REST) begin
			s_side = 1'b1;
			ph = phase_t'(ph - S_SHIFT);
		end
		case (ph)
		PH_SEQ_TAG: begin
			if (b != TAG_SEQUENCE)
				parse_fail(ST_SEQ_TAG);
			else
				prs_phase = PH_SEQ_LEN;
		end
		PH_SEQ_LEN: begin
			prs_seq_len = b[6:0];
			if (b[7] || b == PAD_ZERO)
				parse_fail(ST_SEQ_LEN);
			else
				prs_phase = PH_INT_TAG;
		end
		PH_INT_TAG: begin
			if (b != TAG_INTEGER)
				parse_fail(ST_INT_TAG);
			else
				prs_phase = on_side(PH_INT_LEN, s_side);
		end
		PH_INT_LEN: begin
			// Content bytes of the sequence still to come after this one.
			room = int'(prs_seq_len) - (int'(prs_count) - 1);
			if (b[7] || b == PAD_ZERO || int'(b) > room) begin
				parse_fail(ST_INT_LEN);
			end else begin
				prs_left = b;
				prs_phase = on_side(PH_FIRST, s_side);
			end
		end
		PH_FIRST: begin
			prs_lead = b;
			if (b[7])
				int_dropped[s_side] = 1'b1;
			content_byte(s_side, b);
			if (prs_left != 8'd0)
				prs_phase = on_side(PH_SECOND, s_side);
		end
		PH_SECOND: begin
			if ((prs_lead == PAD_ZERO && !b[7]) || (prs_lead == PAD_ONES && b[7])) begin
				parse_fail(ST_PADDING);
			end else begin
				content_byte(s_side, b);
				if (prs_left != 8'd0)
					prs_phase = on_side(PH_REST, s_side);
			end
		end
		PH_REST: begin
			content_byte(s_side, b);
		end
		PH_DONE: begin
			parse_fail(ST_TRAILING);
		end
		default: begin
		end
		endcase
		if (prs_count < COUNT_CEIL)
			prs_count++;
		if (!is_last)
			return;

		// Total length wins, then the sequence header and its length against the count, then the first later error.
		if (prs_count < MIN_DER_BYTES || prs_count > SIG_MAX_BYTES)
			st = ST_TOTAL_LEN;
		else if (prs_err == ST_SEQ_TAG || prs_err == ST_SEQ_LEN)
			st = prs_err;
		else if (int'(prs_seq_len) + 2 != int'(prs_count))
			st = ST_SEQ_LEN;
		else if (prs_err != ST_OK)
			st = prs_err;
		else if (prs_phase == PH_DONE)
			st = ST_OK;
		else if (prs_phase == PH_SEQ_TAG)
			st = ST_SEQ_TAG;
		else if (prs_phase == PH_SEQ_LEN)
			st = ST_SEQ_LEN;
		else if (prs_phase == PH_INT_TAG || prs_phase == PH_S_INT_TAG)
			st = ST_INT_TAG;
		else
			st = ST_INT_LEN;

		if (st != ST_OK) begin
			w.word = '0;
			w.index = '0;
			w.status = st;
			w.run_end = 1'b1;
			words_due.push_back(w);
		end else begin
			for (int n = 0; n < 2 * WORDS_PER_INT; n++) begin
				s_side = (n >= WORDS_PER_INT);
				base = (n % WORDS_PER_INT) * 8;
				v = '0;
				if (!int_dropped[s_side]) begin
					for (int k = 0; k < 8; k++)
						v = {v[55:0], s_side ? s_val[base + k] : r_val[base + k]};
				end
				w.word = v;
				w.index = 3'(n);
				w.status = ST_OK;
				w.run_end = (n == 2 * WORDS_PER_INT - 1);
				words_due.push_back(w);
			end
		end
		parse_clear();
	endfunction

	// Appends integer content of the given shape to the signature under construction.
	function automatic void put_int(int len, int_kind_t kind);
		for (int i = 0; i < len; i++) begin
			if (i == 0) begin
				case (kind)
				INT_POS: sig_buf.push_back(8'($urandom_range(127, 1)));
				INT_PADDED: sig_buf.push_back(PAD_ZERO);
				INT_NEG: sig_buf.push_back(8'($urandom_range(254, 128)));
				default: sig_buf.push_back(8'($urandom));
				endcase
			end else if (i == 1 && kind == INT_PADDED) begin
				sig_buf.push_back(8'($urandom_range(255, 128)));
			end else begin
				sig_buf.push_back(8'($urandom));
			end
		end
	endfunction

	function automatic int_kind_t pick_kind(int len);
		int k;
		k = $urandom_range(9);
		if (k == 0)
			return INT_NEG;
		if (k == 1)
			return INT_RAW;
		return (len == SIG_INT_BYTES + 1) ? INT_PADDED : INT_POS;
	endfunction

	// Builds SEQUENCE { INTEGER r, INTEGER s } with a consistent sequence length.
	function automatic void form_sig(int r_len, int_kind_t r_kind, int s_len, int_kind_t s_kind);
		sig_buf.delete();
		sig_buf.push_back(TAG_SEQUENCE);
		sig_buf.push_back(8'(r_len + s_len + 4));
		sig_buf.push_back(TAG_INTEGER);
		sig_buf.push_back(8'(r_len));
		put_int(r_len, r_kind);
		sig_buf.push_back(TAG_INTEGER);
		sig_buf.push_back(8'(s_len));
		put_int(s_len, s_kind);
	endfunction

	// Hands the built signature to the driver, last byte marked.
	function automatic void send_sig();
		der_beat_t bt;
		for (int i = 0; i < sig_buf.size(); i++) begin
			bt.data = sig_buf[i];
			bt.is_last = (i == sig_buf.size() - 1);
			der_pending.push_back(bt);
			bytes_queued++;
		end
		sig_buf.delete();
	endfunction

	// A 70-byte well-formed signature with one byte overwritten.
	function automatic void send_patched(int at, logic [7:0] val);
		form_sig(SIG_INT_BYTES, INT_POS, SIG_INT_BYTES, INT_POS);
		sig_buf[at] = val;
		send_sig();
	endfunction

	// Mostly well-formed signatures with random content; the rest are damaged or noise.
	task automatic random_sigs();
		int start;
		int pick;
		int total;
		int r_len;
		int s_len;
		int cut;
		start = bytes_queued;
		while (bytes_queued - start < RANDOM_BYTES) begin
			pick = $urandom_range(99);
			total = (pick < 85) ? $urandom_range(72, 70) : $urandom_range(80, 60);
			r_len = $urandom_range(35, 29);
			s_len = total - 6 - r_len;
			form_sig(r_len, pick_kind(r_len), s_len, pick_kind(s_len));
			if (pick >= 70) begin
				cut = $urandom_range(3);
				case (cut)
				0: sig_buf[$urandom_range(sig_buf.size() - 1)] = 8'($urandom);
				1: repeat ($urandom_range(sig_buf.size() - 1, 1)) void'(sig_buf.pop_back());
				2: repeat ($urandom_range(3, 1)) sig_buf.push_back(8'($urandom));
				default: begin
					sig_buf.delete();
					repeat ($urandom_range(8, 1)) sig_buf.push_back(8'($urandom));
				end
				endcase
			end
			send_sig();
		end
	endtask

	// Waits until every queued byte is taken and every expected beat has arrived.
	task automatic drain();
		while (bytes_taken != bytes_queued || words_due.size() != 0)
			@(posedge clk);
	endtask

	// Byte driver: a new beat goes out once the current one is taken or none is offered.
	always @(negedge clk) begin
		if (!arst_n) begin
			der_if.valid <= 1'b0;
		end else if (!der_if.valid || byte_took) begin
			if (der_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_beat = der_pending.pop_front();
				der_if.valid <= 1'b1;
				der_if.der_byte <= next_beat.data;
				der_if.final_byte <= next_beat.is_last;
			end else begin
				der_if.valid <= 1'b0;
				der_if.der_byte <= 8'($urandom);
				der_if.final_byte <= 1'($urandom);
			end
		end
	end

	// Accepted byte beats feed the in-bench parser.
	always @(posedge clk) begin
		if (arst_n && der_if.valid && der_if.ready) begin
			parse_beat(der_if.der_byte, der_if.final_byte);
			bytes_taken++;
			byte_took <= 1'b1;
		end else begin
			byte_took <= 1'b0;
		end
	end

	// Result ready: random stalls, plus one long hold-off once armed.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_if.ready <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Result monitor: each accepted beat is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (words_due.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, %s %h %0d %0d %0b",
					$time, "actual word, index, status, end", res_if.sig_word,
					res_if.word_index, res_if.status, res_if.run_end);
				mismatches++;
			end else begin
				word_head = words_due.pop_front();
				if (res_if.sig_word !== word_head.word) begin
					$display("%0t: sig_word expected %h actual %h", $time, word_head.word,
						res_if.sig_word);
					mismatches++;
				end
				if (res_if.word_index !== word_head.index) begin
					$display("%0t: word_index expected %0d actual %0d", $time, word_head.index,
						res_if.word_index);
					mismatches++;
				end
				if (res_if.status !== word_head.status) begin
					$display("%0t: status expected %0d actual %0d", $time, word_head.status,
						res_if.status);
					mismatches++;
				end
				if (res_if.run_end !== word_head.run_end) begin
					$display("%0t: run_end expected %0b actual %0b", $time, word_head.run_end,
						res_if.run_end);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((der_if.valid && der_if.ready) || (res_if.valid && res_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		der_if.valid = 1'b0;
		der_if.der_byte = '0;
		der_if.final_byte = 1'b0;
		res_if.ready = 1'b0;
		parse_clear();
		src_idle_pct = 11;
		sink_idle_pct = 59;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A well-formed signature at the upper length limit with extreme contents.
		form_sig(SIG_INT_BYTES + 1, INT_PADDED, SIG_INT_BYTES + 1, INT_PADDED);
		for (int i = 5; i <= 36; i++)
			sig_buf[i] = PAD_ONES;
		sig_buf[40] = 8'h80;
		for (int i = 41; i <= 71; i++)
			sig_buf[i] = PAD_ZERO;
		send_sig();
		// A lone byte fails on total length.
		sig_buf.push_back(TAG_SEQUENCE);
		send_sig();
		drain();

		// Sender mostly idle, receiver mostly ready.
		src_idle_pct = 59;
		sink_idle_pct = 11;
		// Negative R and oversized S come out as zero words with a good status.
		form_sig(31, INT_NEG, 35, INT_POS);
		send_sig();
		drain();

		// Full rate on both sides, opened by a long receiver hold-off.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_arm = 1'b1;
		// A bad S integer tag, then random signatures queued behind it.
		send_patched(36, 8'h04);
		random_sigs();
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && words_due.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: der_ecdsa_signature_parser_top.f
+incdir+design
design/dsig_pkg.sv
design/dsig_byte_if.sv
design/dsig_word_if.sv
design/dsig_parse.sv
design/dsig_emit.sv
design/der_ecdsa_signature_parser_top.sv
bench/testbench.sv
